### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on clk_i, held off while rst_ni is low.
`define PWMAD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in a given cycle, consequent in the next.
`define PWMAD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pwmad_pkg.sv
package pwmad_pkg;

  localparam int ANGLE_BITS       = 14;
  localparam int TICKS_PER_SECOND = 1000000;

  localparam int PERIOD_W  = 16;
  localparam int TIME_W    = 32;
  localparam int TURN_W    = 32;
  localparam int VEL_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  // |turn diff * 2^ANGLE_BITS + angle diff| fits MAG_W bits, signed form CNT_W
  localparam int MAG_W  = TURN_W + ANGLE_BITS;
  localparam int CNT_W  = MAG_W + 1;
  // magnitude is multiplied in two halves
  localparam int LO_W   = (MAG_W + 1) / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = LO_W + TPS_W;
  localparam int DIVD_W = MAG_W + TPS_W;
  localparam int DIV_W  = TIME_W;
  localparam int INIT_W = DIVD_W - DIV_W;
  localparam int REM0_W = (INIT_W > DIV_W) ? INIT_W : DIV_W;
  localparam int ITER_W = $clog2(DIV_W + 1);

  localparam logic [TPS_W-1:0] TPS = TPS_W'(TICKS_PER_SECOND);

  localparam logic [PERIOD_W-1:0]   PERIOD_MIN_RST = PERIOD_W'(800);
  localparam logic [PERIOD_W-1:0]   PERIOD_MAX_RST = PERIOD_W'(1250);
  // half a turn
  localparam logic [ANGLE_BITS-1:0] WRAP_THR_RST   = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  localparam logic [VEL_W-1:0] VEL_POS_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_NEG_MAX = {1'b1, {(VEL_W-1){1'b0}}};

  localparam logic FUNC_CAPTURE = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MIN = 2'd0,
    CFG_PERIOD_MAX = 2'd1,
    CFG_WRAP_THR   = 2'd2,
    CFG_REVERSE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0]   period_min;
    logic [PERIOD_W-1:0]   period_max;
    logic [ANGLE_BITS-1:0] wrap_thr;
    logic                  reverse;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [REM0_W-1:0] rem0;
    logic [DIV_W-1:0]  lo;
    logic [DIV_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic [TURN_W-1:0]     turns;
    logic [VEL_W-1:0]      velocity;
    logic                  in_band;
    logic                  has_angle;
  } res_t;

endpackage

### rtl/core/pwm_angle_sensor_decoder.sv
// An in-band capture waits on the angle divide (cut short if high >= period); a query
// with an interval multiplies, then waits on the velocity divide (cut short on overflow);
// others skip the divider. A request is taken only once the last result is handed on;
// the shared restoring divider makes one quotient bit per cycle (14 angle, 32 velocity
// bits). Reset (rst_ni, async, active low) clears all angle, turn and reference state
// and loads the config defaults; no clearing pass, requests are taken right after reset.
module pwm_angle_sensor_decoder (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pwmad_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pwmad_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   func_i,
  input  logic [pwmad_pkg::PERIOD_W-1:0]         period_ticks_i,
  input  logic [pwmad_pkg::PERIOD_W-1:0]         high_ticks_i,
  input  logic [pwmad_pkg::TIME_W-1:0]           timestamp_us_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [pwmad_pkg::ANGLE_BITS-1:0]       angle_o,
  output logic signed [pwmad_pkg::TURN_W-1:0]    turns_o,
  output logic signed [pwmad_pkg::VEL_W-1:0]     velocity_o,
  output logic                                   in_band_o,
  output logic                                   has_angle_o
);

  pwmad_pkg::cfg_t     cfg_q, cfg_d;
  pwmad_pkg::res_t     res, out_q;
  pwmad_pkg::div_req_t div_req;
  pwmad_pkg::div_rsp_t div_rsp;
  logic                res_valid;
  logic                slot_free;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (pwmad_pkg::cfg_idx_e'(cfg_idx_i))
        pwmad_pkg::CFG_PERIOD_MIN: cfg_d.period_min = cfg_wdata_i[pwmad_pkg::PERIOD_W-1:0];
        pwmad_pkg::CFG_PERIOD_MAX: cfg_d.period_max = cfg_wdata_i[pwmad_pkg::PERIOD_W-1:0];
        pwmad_pkg::CFG_WRAP_THR:   cfg_d.wrap_thr   = cfg_wdata_i[pwmad_pkg::ANGLE_BITS-1:0];
        pwmad_pkg::CFG_REVERSE:    cfg_d.reverse    = cfg_wdata_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  // output register: a finished result moves here when the slot is empty or draining
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && slot_free) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_min <= pwmad_pkg::PERIOD_MIN_RST;
      cfg_q.period_max <= pwmad_pkg::PERIOD_MAX_RST;
      cfg_q.wrap_thr   <= pwmad_pkg::WRAP_THR_RST;
      cfg_q.reverse    <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  pwmad_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .period_ticks_i (period_ticks_i),
    .high_ticks_i   (high_ticks_i),
    .timestamp_us_i (timestamp_us_i),
    .res_o          (res),
    .res_valid_o    (res_valid),
    .res_ready_i    (slot_free),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp)
  );

  pwmad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign angle_o     = out_q.angle;
  assign turns_o     = $signed(out_q.turns);
  assign velocity_o  = $signed(out_q.velocity);
  assign in_band_o   = out_q.in_band;
  assign has_angle_o = out_q.has_angle;

endmodule

### rtl/core/pwmad_div.sv
`include "assert_macros.svh"

module pwmad_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwmad_pkg::div_req_t req_i,
  output pwmad_pkg::div_rsp_t rsp_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic                             ovf_q, ovf_d;
  logic [pwmad_pkg::ITER_W-1:0]     cnt_q, cnt_d;
  logic [pwmad_pkg::DIV_W-1:0]      rem_q, rem_d;
  logic [pwmad_pkg::DIV_W-1:0]      lo_q, lo_d;
  logic [pwmad_pkg::DIV_W-1:0]      div_q, div_d;
  logic [pwmad_pkg::DIV_W:0]        part;
  logic [pwmad_pkg::DIV_W:0]        diff;
  logic                             ge;

  // restoring division, one quotient bit per cycle; quotient shifts into lo
  always_comb begin
    part   = {rem_q, lo_q[pwmad_pkg::DIV_W-1]};
    diff   = part - {1'b0, div_q};
    ge     = part >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    div_d  = div_q;
    if (req_i.start) begin
      div_d = req_i.divisor;
      lo_d  = req_i.lo;
      rem_d = req_i.rem0[pwmad_pkg::DIV_W-1:0];
      cnt_d = req_i.iters;
      // quotient would not fit the requested bit count
      if (req_i.rem0 >= pwmad_pkg::REM0_W'(req_i.divisor)) begin
        ovf_d  = 1'b1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        ovf_d  = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[pwmad_pkg::DIV_W-1:0] : part[pwmad_pkg::DIV_W-1:0];
      lo_d  = {lo_q[pwmad_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - pwmad_pkg::ITER_W'(1);
      if (cnt_q == pwmad_pkg::ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = lo_q;

  `PWMAD_ASSERT(a_div_start_idle, req_i.start |-> !busy_q, "divider request while busy")
  `PWMAD_ASSERT(a_div_rem_bound, busy_q |-> (rem_q < div_q), "partial remainder not below divisor")
  `PWMAD_ASSERT_NEXT(a_div_finish, busy_q && cnt_q == pwmad_pkg::ITER_W'(1), done_q && !busy_q, "divider missed its last step")

endmodule

### rtl/core/pwmad_seq.sv
`include "assert_macros.svh"

module pwmad_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pwmad_pkg::cfg_t                      cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [pwmad_pkg::PERIOD_W-1:0]       period_ticks_i,
  input  logic [pwmad_pkg::PERIOD_W-1:0]       high_ticks_i,
  input  logic [pwmad_pkg::TIME_W-1:0]         timestamp_us_i,
  output pwmad_pkg::res_t                      res_o,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output pwmad_pkg::div_req_t                  div_req_o,
  input  pwmad_pkg::div_rsp_t                  div_rsp_i
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_ANG_DIV = 11'b000_0000_0010,
    ST_Q_DIFF  = 11'b000_0000_0100,
    ST_Q_CNT   = 11'b000_0000_1000,
    ST_Q_ABS   = 11'b000_0001_0000,
    ST_MUL_LO  = 11'b000_0010_0000,
    ST_MUL_HI  = 11'b000_0100_0000,
    ST_MUL_ACC = 11'b000_1000_0000,
    ST_VEL_GO  = 11'b001_0000_0000,
    ST_VEL_DIV = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_e;

  localparam int AB = pwmad_pkg::ANGLE_BITS;

  state_e state_q, state_d;

  logic [AB-1:0]                    prev_angle_q, prev_angle_d;
  logic                             angle_valid_q, angle_valid_d;
  logic                             band_q, band_d;
  logic [pwmad_pkg::TURN_W-1:0]     turn_q, turn_d;
  logic [AB-1:0]                    ref_angle_q, ref_angle_d;
  logic [pwmad_pkg::TURN_W-1:0]     ref_turns_q, ref_turns_d;
  logic [pwmad_pkg::TIME_W-1:0]     ref_time_q, ref_time_d;
  logic                             ref_valid_q, ref_valid_d;
  logic [pwmad_pkg::TIME_W-1:0]     last_ivl_q, last_ivl_d;

  logic [pwmad_pkg::TIME_W-1:0]     ts_q, ts_d;
  logic [pwmad_pkg::TURN_W-1:0]     td_q, td_d;
  logic [AB:0]                      adiff_q, adiff_d;
  logic [pwmad_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [pwmad_pkg::MAG_W-1:0]      mag_q, mag_d;
  logic                             neg_q, neg_d;
  logic [pwmad_pkg::PROD_W-1:0]     pp_q, pp_d;
  logic [pwmad_pkg::DIVD_W-1:0]     dvd_q, dvd_d;
  logic [pwmad_pkg::VEL_W-1:0]      vel_q, vel_d;

  logic [AB-1:0]                    ang_sel, ang_new;
  logic signed [AB+1:0]             step, thr_pos, thr_neg;
  logic [pwmad_pkg::TIME_W-1:0]     ivl, ivl_sel;
  logic [pwmad_pkg::CNT_W-1:0]      abs_val;
  logic [pwmad_pkg::LO_W-1:0]       mul_a;
  logic [pwmad_pkg::PROD_W-1:0]     prod;
  logic [pwmad_pkg::VEL_W-1:0]      vel_sat;

  always_comb begin
    ang_sel = div_rsp_i.ovf ? {AB{1'b1}} : div_rsp_i.quot[AB-1:0];
    ang_new = cfg_i.reverse ? (AB'(0) - ang_sel) : ang_sel;
    step    = $signed({2'b00, ang_new}) - $signed({2'b00, prev_angle_q});
    thr_pos = $signed({2'b00, cfg_i.wrap_thr});
    thr_neg = -thr_pos;

    ivl     = ts_q - ref_time_q;
    ivl_sel = (ivl == '0) ? last_ivl_q : ivl;

    abs_val = cnt_q[pwmad_pkg::CNT_W-1] ? (pwmad_pkg::CNT_W'(0) - cnt_q) : cnt_q;

    mul_a = (state_q == ST_MUL_LO) ? mag_q[pwmad_pkg::LO_W-1:0]
                                   : pwmad_pkg::LO_W'(mag_q[pwmad_pkg::MAG_W-1:pwmad_pkg::LO_W]);
    prod  = pwmad_pkg::PROD_W'(mul_a) * pwmad_pkg::PROD_W'(pwmad_pkg::TPS);

    if (div_rsp_i.ovf) begin
      vel_sat = neg_q ? pwmad_pkg::VEL_NEG_MAX : pwmad_pkg::VEL_POS_MAX;
    end else if (!neg_q) begin
      vel_sat = div_rsp_i.quot[pwmad_pkg::VEL_W-1] ? pwmad_pkg::VEL_POS_MAX
                                                    : div_rsp_i.quot;
    end else begin
      vel_sat = (div_rsp_i.quot > pwmad_pkg::VEL_NEG_MAX) ? pwmad_pkg::VEL_NEG_MAX
                                                           : (pwmad_pkg::VEL_W'(0) - div_rsp_i.quot);
    end
  end

  always_comb begin
    state_d       = state_q;
    prev_angle_d  = prev_angle_q;
    angle_valid_d = angle_valid_q;
    band_d        = band_q;
    turn_d        = turn_q;
    ref_angle_d   = ref_angle_q;
    ref_turns_d   = ref_turns_q;
    ref_time_d    = ref_time_q;
    ref_valid_d   = ref_valid_q;
    last_ivl_d    = last_ivl_q;
    ts_d          = ts_q;
    td_d          = td_q;
    adiff_d       = adiff_q;
    cnt_d         = cnt_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    pp_d          = pp_q;
    dvd_d         = dvd_q;
    vel_d         = vel_q;

    div_req_o.start   = 1'b0;
    div_req_o.rem0    = pwmad_pkg::REM0_W'(high_ticks_i);
    div_req_o.lo      = '0;
    div_req_o.divisor = pwmad_pkg::DIV_W'(period_ticks_i);
    div_req_o.iters   = pwmad_pkg::ITER_W'(AB);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          vel_d = '0;
          ts_d  = timestamp_us_i;
          if (func_i == pwmad_pkg::FUNC_CAPTURE) begin
            if (period_ticks_i == '0) begin
              state_d = ST_DONE;
            end else if (period_ticks_i <= cfg_i.period_min ||
                         period_ticks_i >= cfg_i.period_max) begin
              band_d  = 1'b0;
              state_d = ST_DONE;
            end else begin
              band_d          = 1'b1;
              div_req_o.start = 1'b1;
              state_d         = ST_ANG_DIV;
            end
          end else begin
            if (!angle_valid_q) begin
              state_d = ST_DONE;
            end else if (!ref_valid_q) begin
              // first query only sets the reference
              ref_angle_d = prev_angle_q;
              ref_turns_d = turn_q;
              ref_time_d  = timestamp_us_i;
              ref_valid_d = 1'b1;
              state_d     = ST_DONE;
            end else begin
              state_d = ST_Q_DIFF;
            end
          end
        end
      end
      ST_ANG_DIV: begin
        if (div_rsp_i.done) begin
          if (angle_valid_q) begin
            if (step >= thr_pos) begin
              turn_d = turn_q - pwmad_pkg::TURN_W'(1);
            end else if (step <= thr_neg) begin
              turn_d = turn_q + pwmad_pkg::TURN_W'(1);
            end
          end
          prev_angle_d  = ang_new;
          angle_valid_d = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_Q_DIFF: begin
        last_ivl_d  = ivl_sel;
        td_d        = turn_q - ref_turns_q;
        adiff_d     = {1'b0, prev_angle_q} - {1'b0, ref_angle_q};
        ref_angle_d = prev_angle_q;
        ref_turns_d = turn_q;
        ref_time_d  = ts_q;
        state_d     = (ivl_sel == '0) ? ST_DONE : ST_Q_CNT;
      end
      ST_Q_CNT: begin
        cnt_d = {td_q[pwmad_pkg::TURN_W-1], td_q, {AB{1'b0}}}
              + {{(pwmad_pkg::CNT_W-AB-1){adiff_q[AB]}}, adiff_q};
        state_d = ST_Q_ABS;
      end
      ST_Q_ABS: begin
        neg_d   = cnt_q[pwmad_pkg::CNT_W-1];
        mag_d   = abs_val[pwmad_pkg::MAG_W-1:0];
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        pp_d    = prod;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        dvd_d   = pwmad_pkg::DIVD_W'(pp_q);
        pp_d    = prod;
        state_d = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        dvd_d   = dvd_q + (pwmad_pkg::DIVD_W'(pp_q) << pwmad_pkg::LO_W);
        state_d = ST_VEL_GO;
      end
      ST_VEL_GO: begin
        div_req_o.start   = 1'b1;
        div_req_o.rem0    = pwmad_pkg::REM0_W'(dvd_q[pwmad_pkg::DIVD_W-1:pwmad_pkg::DIV_W]);
        div_req_o.lo      = dvd_q[pwmad_pkg::DIV_W-1:0];
        div_req_o.divisor = last_ivl_q;
        div_req_o.iters   = pwmad_pkg::ITER_W'(pwmad_pkg::DIV_W);
        state_d           = ST_VEL_DIV;
      end
      ST_VEL_DIV: begin
        if (div_rsp_i.done) begin
          vel_d   = vel_sat;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      prev_angle_q  <= '0;
      angle_valid_q <= 1'b0;
      band_q        <= 1'b0;
      turn_q        <= '0;
      ref_angle_q   <= '0;
      ref_turns_q   <= '0;
      ref_time_q    <= '0;
      ref_valid_q   <= 1'b0;
      last_ivl_q    <= '0;
    end else begin
      state_q       <= state_d;
      prev_angle_q  <= prev_angle_d;
      angle_valid_q <= angle_valid_d;
      band_q        <= band_d;
      turn_q        <= turn_d;
      ref_angle_q   <= ref_angle_d;
      ref_turns_q   <= ref_turns_d;
      ref_time_q    <= ref_time_d;
      ref_valid_q   <= ref_valid_d;
      last_ivl_q    <= last_ivl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q    <= ts_d;
    td_q    <= td_d;
    adiff_q <= adiff_d;
    cnt_q   <= cnt_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    pp_q    <= pp_d;
    dvd_q   <= dvd_d;
    vel_q   <= vel_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  assign res_o.angle     = prev_angle_q;
  assign res_o.turns     = turn_q;
  assign res_o.velocity  = vel_q;
  assign res_o.in_band   = band_q;
  assign res_o.has_angle = angle_valid_q;

  `PWMAD_ASSERT(a_ref_needs_angle, ref_valid_q |-> angle_valid_q, "reference set without an angle")
  `PWMAD_ASSERT(a_angle_sticky, !$fell(angle_valid_q), "angle valid flag dropped")
  `PWMAD_ASSERT(a_div_done_wait, div_rsp_i.done |-> (state_q == ST_ANG_DIV || state_q == ST_VEL_DIV), "divider result with no waiting request")

endmodule
